/* sv/rwhp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rwhp_pkg;

    typedef enum logic [8:0] {
        PH_IDLE       = 9'b0_0000_0001,
        PH_RIFF_TAG   = 9'b0_0000_0010,
        PH_RIFF_SIZE  = 9'b0_0000_0100,
        PH_WAVE_TAG   = 9'b0_0000_1000,
        PH_CHUNK_TAG  = 9'b0_0001_0000,
        PH_CHUNK_SIZE = 9'b0_0010_0000,
        PH_FMT_BODY   = 9'b0_0100_0000,
        PH_SKIP       = 9'b0_1000_0000,
        PH_DONE       = 9'b1_0000_0000
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NOT_RIFF    = 3'd1,
        ST_NOT_WAVE    = 3'd2,
        ST_NOT_PCM     = 3'd3,
        ST_BAD_FORMAT  = 3'd4,
        ST_DATA_NO_FMT = 3'd5,
        ST_TRUNCATED   = 3'd6
    } status_t;

    localparam int          RATE_W       = 20;
    localparam int          ADDR_W       = 3;
    localparam logic [31:0] TAG_RIFF     = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE     = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT      = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA     = 32'h6461_7461;
    localparam logic [RATE_W-1:0] RATE_MIN_RST = 20'd8000;
    localparam logic [RATE_W-1:0] RATE_MAX_RST = 20'd48000;
    localparam logic [15:0] FMT_PCM      = 16'd1;
    localparam logic [31:0] FMT_BODY_LEN = 32'd16;
    localparam logic [1:0]  LAST_HDR_IDX = 2'd3;
    localparam logic [3:0]  LAST_FMT_IDX = 4'd15;

endpackage

`default_nettype wire

/* sv/riff_wave_header_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

// An accepted input beat is held in the input register, and its result beat in the result register.
// Throughput: one byte per cycle; input stalls only while a result is held by out_stall
// and the byte in the input register would produce another result.
// Reset: parser idle until a file_start beat, rate_min = 8000, rate_max = 48000,
// pipeline empty.
module riff_wave_header_parser (
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [7:0]                  data_byte,
    input  wire logic                        file_start,
    input  wire logic                        end_of_file,

    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [2:0]                       status,
    output logic [31:0]                      sample_rate,
    output logic [15:0]                      channel_count,
    output logic [15:0]                      bits_per_sample,
    output logic [31:0]                      data_len,
    output logic [31:0]                      data_offset,

    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [rwhp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import rwhp_pkg::*;

    // configuration
    logic [RATE_W-1:0] rate_min_reg;
    logic [RATE_W-1:0] rate_max_reg;
    logic              cfg_wr;

    // input register
    logic       ib_valid_reg;
    logic [7:0] ib_byte_reg;
    logic       ib_start_reg;
    logic       ib_eof_reg;

    // parser state
    phase_t      phase_reg, phase_next;
    logic [1:0]  hcnt_reg, hcnt_next;
    logic [3:0]  fcnt_reg, fcnt_next;
    logic [32:0] skip_reg, skip_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] size_reg, size_next;
    logic        have_fmt_reg, have_fmt_next;
    logic [15:0] format_reg, format_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic [31:0] fpos_reg, fpos_next;

    // result register
    logic        out_valid_reg;
    status_t     status_reg;
    logic [31:0] rate_out_reg;
    logic [15:0] chan_out_reg;
    logic [15:0] bits_out_reg;
    logic [31:0] dsize_out_reg;
    logic [31:0] doff_out_reg;

    // combinational
    phase_t      ph_cur;
    logic        active;
    logic [31:0] tag_cur;
    logic [31:0] tag_new;
    logic [31:0] size_new;
    logic [32:0] skip_len;
    logic        rate_ok;
    logic        chan_ok;
    logic        res_valid;
    status_t     res_status;
    logic [31:0] res_dsize;
    logic [31:0] res_doff;
    logic        proceed;
    logic        in_accept;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = paddr[2] ? {{(32-RATE_W){1'b0}}, rate_max_reg}
                             : {{(32-RATE_W){1'b0}}, rate_min_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_min_reg <= RATE_MIN_RST;
            rate_max_reg <= RATE_MAX_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2])
            begin
                rate_max_reg <= pwdata[RATE_W-1:0];
            end
            else
            begin
                rate_min_reg <= pwdata[RATE_W-1:0];
            end
        end
    end

    // parse step for the byte in the input register
    assign ph_cur   = ib_start_reg ? PH_RIFF_TAG : phase_reg;
    assign active   = ib_start_reg || (phase_reg != PH_IDLE && phase_reg != PH_DONE);
    assign tag_cur  = ib_start_reg ? 32'd0 : tag_reg;
    assign tag_new  = {tag_cur[23:0], ib_byte_reg};
    assign size_new = {ib_byte_reg, size_reg[31:8]};
    assign skip_len = {1'b0, size_new} + {32'd0, size_new[0]};
    assign rate_ok  = (rate_reg >= {{(32-RATE_W){1'b0}}, rate_min_reg})
                   && (rate_reg <= {{(32-RATE_W){1'b0}}, rate_max_reg});
    assign chan_ok  = (chan_reg == 16'd1) || (chan_reg == 16'd2);

    always_comb
    begin
        phase_next    = phase_reg;
        hcnt_next     = ib_start_reg ? 2'd0 : hcnt_reg;
        fcnt_next     = fcnt_reg;
        skip_next     = skip_reg;
        tag_next      = tag_cur;
        size_next     = ib_start_reg ? 32'd0 : size_reg;
        have_fmt_next = ib_start_reg ? 1'b0 : have_fmt_reg;
        format_next   = ib_start_reg ? 16'd0 : format_reg;
        chan_next     = ib_start_reg ? 16'd0 : chan_reg;
        rate_next     = ib_start_reg ? 32'd0 : rate_reg;
        bits_next     = ib_start_reg ? 16'd0 : bits_reg;
        fpos_next     = ib_start_reg ? 32'd0 : fpos_reg + 32'd1;
        res_valid     = 1'b0;
        res_status    = ST_OK;
        res_dsize     = 32'd0;
        res_doff      = 32'd0;

        if (active)
        begin
            phase_next = ph_cur;
            unique case (ph_cur)
                PH_RIFF_TAG, PH_WAVE_TAG:
                begin
                    tag_next  = tag_new;
                    hcnt_next = hcnt_reg + 2'd1;
                    if (ib_start_reg)
                    begin
                        hcnt_next = 2'd1;
                    end
                    else if (hcnt_reg == LAST_HDR_IDX)
                    begin
                        hcnt_next = 2'd0;
                        if (ph_cur == PH_RIFF_TAG)
                        begin
                            if (tag_new != TAG_RIFF)
                            begin
                                res_valid  = 1'b1;
                                res_status = ST_NOT_RIFF;
                            end
                            else
                            begin
                                phase_next = PH_RIFF_SIZE;
                            end
                        end
                        else if (tag_new != TAG_WAVE)
                        begin
                            res_valid  = 1'b1;
                            res_status = ST_NOT_WAVE;
                        end
                        else
                        begin
                            phase_next = PH_CHUNK_TAG;
                            tag_next   = 32'd0;
                        end
                    end
                end
                PH_RIFF_SIZE:
                begin
                    hcnt_next = hcnt_reg + 2'd1;
                    if (hcnt_reg == LAST_HDR_IDX)
                    begin
                        phase_next = PH_WAVE_TAG;
                        tag_next   = 32'd0;
                    end
                end
                PH_CHUNK_TAG:
                begin
                    tag_next  = tag_new;
                    hcnt_next = hcnt_reg + 2'd1;
                    if (hcnt_reg == LAST_HDR_IDX)
                    begin
                        phase_next = PH_CHUNK_SIZE;
                        size_next  = 32'd0;
                    end
                end
                PH_CHUNK_SIZE:
                begin
                    size_next = size_new;
                    hcnt_next = hcnt_reg + 2'd1;
                    if (hcnt_reg == LAST_HDR_IDX)
                    begin
                        if (tag_reg == TAG_FMT)
                        begin
                            phase_next = PH_FMT_BODY;
                            fcnt_next  = 4'd0;
                        end
                        else if (tag_reg == TAG_DATA)
                        begin
                            res_valid = 1'b1;
                            if (!have_fmt_reg)
                            begin
                                res_status = ST_DATA_NO_FMT;
                            end
                            else
                            begin
                                res_dsize = size_new;
                                res_doff  = fpos_reg + 32'd2;
                            end
                        end
                        else if (skip_len == 33'd0)
                        begin
                            phase_next = PH_CHUNK_TAG;
                            tag_next   = 32'd0;
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                            skip_next  = skip_len;
                        end
                    end
                end
                PH_FMT_BODY:
                begin
                    fcnt_next = fcnt_reg + 4'd1;
                    priority if (fcnt_reg == 4'd0)
                        format_next[7:0] = ib_byte_reg;
                    else if (fcnt_reg == 4'd1)
                        format_next[15:8] = ib_byte_reg;
                    else if (fcnt_reg == 4'd2)
                        chan_next[7:0] = ib_byte_reg;
                    else if (fcnt_reg == 4'd3)
                        chan_next[15:8] = ib_byte_reg;
                    else if (fcnt_reg < 4'd8)
                        rate_next = {ib_byte_reg, rate_reg[31:8]};
                    else if (fcnt_reg == 4'd14)
                        bits_next[7:0] = ib_byte_reg;
                    else if (fcnt_reg == LAST_FMT_IDX)
                        bits_next[15:8] = ib_byte_reg;
                    else
                        fcnt_next = fcnt_reg + 4'd1;

                    if (fcnt_reg == LAST_FMT_IDX)
                    begin
                        if (format_reg != FMT_PCM)
                        begin
                            res_valid  = 1'b1;
                            res_status = ST_NOT_PCM;
                        end
                        else if (!rate_ok || !chan_ok)
                        begin
                            res_valid  = 1'b1;
                            res_status = ST_BAD_FORMAT;
                        end
                        else
                        begin
                            have_fmt_next = 1'b1;
                            if (size_reg > FMT_BODY_LEN)
                            begin
                                phase_next = PH_SKIP;
                                skip_next  = {1'b0, size_reg - FMT_BODY_LEN};
                            end
                            else
                            begin
                                phase_next = PH_CHUNK_TAG;
                                hcnt_next  = 2'd0;
                                tag_next   = 32'd0;
                            end
                        end
                    end
                end
                PH_SKIP:
                begin
                    if (skip_reg == 33'd1)
                    begin
                        phase_next = PH_CHUNK_TAG;
                        hcnt_next  = 2'd0;
                        tag_next   = 32'd0;
                    end
                    else
                    begin
                        skip_next = skip_reg - 33'd1;
                    end
                end
                default:
                begin
                    phase_next = ph_cur;
                end
            endcase

            if (!res_valid && ib_eof_reg)
            begin
                res_valid  = 1'b1;
                res_status = ST_TRUNCATED;
            end
            if (res_valid)
            begin
                phase_next = PH_DONE;
            end
        end
        else
        begin
            fpos_next = fpos_reg;
        end
    end

    // handshake
    assign proceed   = ib_valid_reg && !(res_valid && out_valid_reg && out_stall);
    assign in_stall  = ib_valid_reg && !proceed;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ib_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            ib_valid_reg <= 1'b1;
        end
        else if (proceed)
        begin
            ib_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ib_byte_reg  <= data_byte;
            ib_start_reg <= file_start;
            ib_eof_reg   <= end_of_file;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            hcnt_reg     <= 2'd0;
            fcnt_reg     <= 4'd0;
            skip_reg     <= 33'd0;
            tag_reg      <= 32'd0;
            size_reg     <= 32'd0;
            have_fmt_reg <= 1'b0;
            format_reg   <= 16'd0;
            chan_reg     <= 16'd0;
            rate_reg     <= 32'd0;
            bits_reg     <= 16'd0;
            fpos_reg     <= 32'd0;
        end
        else if (proceed)
        begin
            phase_reg    <= phase_next;
            hcnt_reg     <= hcnt_next;
            fcnt_reg     <= fcnt_next;
            skip_reg     <= skip_next;
            tag_reg      <= tag_next;
            size_reg     <= size_next;
            have_fmt_reg <= have_fmt_next;
            format_reg   <= format_next;
            chan_reg     <= chan_next;
            rate_reg     <= rate_next;
            bits_reg     <= bits_next;
            fpos_reg     <= fpos_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proceed && res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proceed && res_valid)
        begin
            status_reg    <= res_status;
            rate_out_reg  <= (res_status == ST_OK) ? rate_reg : 32'd0;
            chan_out_reg  <= (res_status == ST_OK) ? chan_reg : 16'd0;
            bits_out_reg  <= (res_status == ST_OK) ? bits_reg : 16'd0;
            dsize_out_reg <= res_dsize;
            doff_out_reg  <= res_doff;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign sample_rate     = rate_out_reg;
    assign channel_count   = chan_out_reg;
    assign bits_per_sample = bits_out_reg;
    assign data_len        = dsize_out_reg;
    assign data_offset     = doff_out_reg;

endmodule

`default_nettype wire
